### design/frd_pkg.sv
// constants and result layout for the fragment reassembly deframer
// no dependencies; imported by fragment_reassembly_deframer_core
package frd_pkg;

    localparam int unsigned FRAG_PAYLOAD_DEF = 251;
    localparam int unsigned HEADER_BYTES     = 4;

    // header byte positions within a transfer packet
    localparam logic [7:0] POS_SEQUENCE = 8'd0;
    localparam logic [7:0] POS_FLAGS    = 8'd1;
    localparam logic [7:0] POS_SIZE_LOW = 8'd2;
    localparam logic [7:0] POS_ORIGIN   = 8'd3;

    // bytes past this count are ignored
    localparam logic [7:0] MAX_BYTES = 8'd255;

    // flags byte layout
    localparam int unsigned CONT_BIT   = 4;
    localparam logic [7:0]  KIND_MASK  = 8'h0F;

    localparam int unsigned OUT_BITS = 47;
    localparam int unsigned OUT_TDATA_BITS = 48;

    typedef struct packed {
        logic        fragment_rejected;
        logic [3:0]  packet_kind;
        logic [15:0] packet_length;
        logic        packet_complete;
        logic [7:0]  write_data;
        logic [15:0] write_address;
        logic        write_enable;
    } frd_result_t;

endpackage

### design/fragment_reassembly_deframer_core.sv
// fragment reassembly deframer: header parse, sequence check, buffer write generation
// depends on frd_pkg for header positions, flag layout and the result struct
//
// usage
//   s_* carries the bytes of transfer packets, one byte per beat, header first;
//   s_tlast marks the last byte of each packet. every input beat yields exactly
//   one result beat on m_*: a buffer write (enable, address, data) plus, on the
//   last byte, completion (length, kind) or rejection.
//   an input beat reaches m_* through one input register and one result register,
//   with the header/sequence logic between them.
//   throughput is one byte per cycle; the input register takes a new beat while a
//   result waits, and only both registers full with m_tready low stalls s_tready.
//   when the receiver stalls, the result beat holds on m_tdata and the input
//   register keeps the next byte; no state advances until the result moves on.
//   reset clears the expected sequence, the byte counter, the captured header
//   and both pipeline valids, so the next byte is taken as a header start.
//   continuation writes land at FRAGMENT_PAYLOAD * (sequence - origin) + offset.
module fragment_reassembly_deframer_core
    import frd_pkg::*;
#(
    parameter int unsigned FRAGMENT_PAYLOAD = FRAG_PAYLOAD_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] rx_byte
    input  logic                      s_tlast,   // end_of_fragment
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] write_enable, [16:1] write_address, [24:17] write_data,
    // [25] packet_complete, [41:26] packet_length, [45:42] packet_kind,
    // [46] fragment_rejected, [47] zero
    output logic [OUT_TDATA_BITS-1:0] m_tdata
);

    localparam logic [7:0]  FP8  = FRAGMENT_PAYLOAD[7:0];
    localparam logic [16:0] FP17 = {9'd0, FP8};
    localparam logic [7:0]  HDR8 = HEADER_BYTES[7:0];

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    frd_result_t out_result_reg;
    frd_result_t result;

    logic [7:0]  expected_seq_reg,  expected_seq_next;
    logic [7:0]  byte_pos_reg,      byte_pos_next;
    logic [7:0]  hdr_seq_reg,       hdr_seq_next;
    logic [7:0]  hdr_flags_reg,     hdr_flags_next;
    logic [7:0]  hdr_size_low_reg,  hdr_size_low_next;
    logic [7:0]  hdr_origin_reg,    hdr_origin_next;
    logic [15:0] cur_length_reg,    cur_length_next;
    logic        frag_ok_reg,       frag_ok_next;

    logic        advance;
    logic        taken;
    logic        cont;
    logic [7:0]  k;
    logic [7:0]  distance;
    logic [16:0] base;
    logic [16:0] got;
    logic [7:0]  total;
    logic [15:0] limit;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS - OUT_BITS){1'b0}}, out_result_reg};

    always_comb
    begin
        expected_seq_next = expected_seq_reg;
        byte_pos_next     = byte_pos_reg;
        hdr_seq_next      = hdr_seq_reg;
        hdr_flags_next    = hdr_flags_reg;
        hdr_size_low_next = hdr_size_low_reg;
        hdr_origin_next   = hdr_origin_reg;
        cur_length_next   = cur_length_reg;
        frag_ok_next      = frag_ok_reg;
        result            = '0;

        taken    = byte_pos_reg != MAX_BYTES;
        cont     = hdr_flags_reg[CONT_BIT];
        k        = byte_pos_reg - HDR8;
        distance = hdr_seq_reg - hdr_origin_reg;
        base     = FP17 * {9'd0, distance};
        limit    = (cur_length_reg > {8'd0, FP8}) ? {8'd0, FP8} : cur_length_reg;

        if (advance)
        begin
            if (taken)
            begin
                case (byte_pos_reg)
                    POS_SEQUENCE: hdr_seq_next      = in_byte_reg;
                    POS_FLAGS:    hdr_flags_next    = in_byte_reg;
                    POS_SIZE_LOW: hdr_size_low_next = in_byte_reg;
                    POS_ORIGIN:
                    begin
                        hdr_origin_next = in_byte_reg;
                        frag_ok_next    = !cont || (hdr_seq_reg == expected_seq_reg);
                        if (!cont)
                            cur_length_next = {in_byte_reg, hdr_size_low_reg};
                    end
                    default:
                    begin
                        if (frag_ok_reg)
                        begin
                            if (!cont)
                            begin
                                if ({8'd0, k} < limit)
                                begin
                                    result.write_enable  = 1'b1;
                                    result.write_address = {8'd0, k};
                                    result.write_data    = in_byte_reg;
                                end
                            end
                            else
                            begin
                                result.write_enable  = 1'b1;
                                result.write_address = 16'(base + {9'd0, k});
                                result.write_data    = in_byte_reg;
                            end
                        end
                    end
                endcase
                byte_pos_next = byte_pos_reg + 8'd1;
            end

            if (in_last_reg)
            begin
                // header fields as updated by this byte
                total = taken ? (byte_pos_reg + 8'd1) : MAX_BYTES;
                got   = 17'(FP17 * {9'd0, hdr_seq_next - hdr_origin_next})
                        + {9'd0, total - HDR8};
                if (total < HDR8 || !frag_ok_next)
                begin
                    result.fragment_rejected = 1'b1;
                end
                else
                begin
                    if (hdr_flags_next[CONT_BIT] ? (got == {1'b0, cur_length_next})
                                                 : (cur_length_next <= {8'd0, FP8}))
                    begin
                        result.packet_complete = 1'b1;
                        result.packet_length   = cur_length_next;
                        result.packet_kind     = 4'(hdr_flags_next & KIND_MASK);
                    end
                    expected_seq_next = hdr_seq_next + 8'd1;
                end
                byte_pos_next = '0;
                frag_ok_next  = 1'b0;
            end
            else
            begin
                total = '0;
                got   = '0;
            end
        end
        else
        begin
            total = '0;
            got   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            expected_seq_reg <= '0;
            byte_pos_reg     <= '0;
            hdr_seq_reg      <= '0;
            hdr_flags_reg    <= '0;
            hdr_size_low_reg <= '0;
            hdr_origin_reg   <= '0;
            cur_length_reg   <= '0;
            frag_ok_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            expected_seq_reg <= expected_seq_next;
            byte_pos_reg     <= byte_pos_next;
            hdr_seq_reg      <= hdr_seq_next;
            hdr_flags_reg    <= hdr_flags_next;
            hdr_size_low_reg <= hdr_size_low_next;
            hdr_origin_reg   <= hdr_origin_next;
            cur_length_reg   <= cur_length_next;
            frag_ok_reg      <= frag_ok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
            out_result_reg <= result;
    end

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    a_last_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (byte_pos_reg == '0 && !frag_ok_reg))
        else $error("byte counter not cleared after last byte");

    a_complete_xor_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_result_reg.packet_complete
                            && out_result_reg.fragment_rejected))
        else $error("fragment both completed and rejected");

    a_kind_only_on_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_result_reg.packet_complete)
            |-> (out_result_reg.packet_kind == '0 && out_result_reg.packet_length == '0))
        else $error("length or kind set without completion");
`endif

endmodule
